// File: src/nfr_pkg.sv
// Shared types, codes and the CRC-8 step of the nibble-complement frame receiver.
package nfr_pkg;

    localparam int CfgIdxW    = 8;
    localparam int CfgDataW   = 16;
    localparam int InDataW    = 8;
    localparam int OutDataW   = 24;
    localparam int KindW      = 3;
    localparam logic [7:0] CrcPoly = 8'h8C;

    localparam logic [CfgIdxW-1:0] RegTimeout  = 8'd0;
    localparam logic [CfgIdxW-1:0] RegMaxPay   = 8'd1;
    localparam logic [CfgIdxW-1:0] RegStart    = 8'd2;
    localparam logic [CfgIdxW-1:0] RegEnd      = 8'd3;

    typedef enum logic [KindW-1:0] {
        K_DATA     = 3'd0,
        K_OK       = 3'd1,
        K_BAD_CHAR = 3'd2,
        K_BAD_CRC  = 3'd3,
        K_OVERFLOW = 3'd4,
        K_TIMEOUT  = 3'd5
    } t_kind;

    typedef struct packed {
        logic        in_frame;
        logic        seen_end;
        logic        expect_high;
        logic [3:0]  high_nibble;
        logic [7:0]  payload_count;
        logic [7:0]  running_crc;
        logic [15:0] elapsed_ticks;
    } t_state;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [7:0]  max_payload;
        logic [7:0]  start_code;
        logic [7:0]  end_code;
    } t_cfg;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
    } t_result;

    localparam t_state StateIdle = '{
        in_frame:      1'b0,
        seen_end:      1'b0,
        expect_high:   1'b1,
        high_nibble:   4'd0,
        payload_count: 8'd0,
        running_crc:   8'd0,
        elapsed_ticks: 16'd0
    };

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b_in);
        logic [7:0] crc;
        logic [7:0] b;
        logic       mix;
        crc = crc_in;
        b   = b_in;
        for (int i = 0; i < 8; i++) begin
            mix = crc[0] ^ b[0];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ CrcPoly;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

endpackage

// File: src/nibble_complement_frame_receiver_top.sv
// Top level of the nibble-complement frame receiver with CRC-8 check.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata rx_byte, tuser func
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata data/index/length, tuser kind
//  cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// One request per cycle unless a stalled output has filled the queue: a request is held in an
// input register, decoded with an unrolled CRC-8 step, and any result it yields is pushed into a
// two-entry output queue; it passes the input register and then the queue before it is valid.
// Synchronous active-low reset returns the frame state, config registers and queue pointers to defaults.
// A stalled output fills the queue; input stalls only when queue and input are full.
module nibble_complement_frame_receiver_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [nfr_pkg::InDataW-1:0]      s_axis_tdata,   // [7:0] rx_byte
    input  logic                             s_axis_tuser,   // [0] func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [nfr_pkg::OutDataW-1:0]     m_axis_tdata,   // [7:0] data_byte,
                                                             // [15:8] byte_index,
                                                             // [23:16] frame_length
    output logic [nfr_pkg::KindW-1:0]        m_axis_tuser,   // [2:0] kind
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nfr_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [nfr_pkg::CfgDataW-1:0]     i_cfg_data
);
    import nfr_pkg::*;

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    logic       r_in_valid;
    logic       r_in_func;
    logic [7:0] r_in_byte;
    t_result    r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       res_valid;
    t_result    res;
    logic       pop;
    logic       proc;
    logic       push;

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign proc          = r_in_valid && ((r_cnt != 2'd2) || pop);
    assign push          = proc && res_valid;
    assign s_axis_tready = !r_in_valid || proc;
    assign m_axis_tuser  = r_q[r_rp].kind;
    assign m_axis_tdata  = {r_q[r_rp].frame_length, r_q[r_rp].byte_index,
                            r_q[r_rp].data_byte};

    nfr_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_func      (r_in_func),
        .i_rx_byte   (r_in_byte),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{timeout_ticks: 16'd100, max_payload: 8'd255,
                       start_code: 8'd2, end_code: 8'd3};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegTimeout: r_cfg.timeout_ticks <= i_cfg_data;
                RegMaxPay:  r_cfg.max_payload   <= i_cfg_data[7:0];
                RegStart:   r_cfg.start_code    <= i_cfg_data[7:0];
                RegEnd:     r_cfg.end_code      <= i_cfg_data[7:0];
                default:    r_cfg               <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_func <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StateIdle;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: src/nfr_step.sv
// Per-request decode step: next frame state and optional result.
module nfr_step (
    input  nfr_pkg::t_cfg    i_cfg,
    input  nfr_pkg::t_state  i_state,
    input  logic             i_func,
    input  logic [7:0]       i_rx_byte,
    output nfr_pkg::t_state  o_state,
    output logic             o_res_valid,
    output nfr_pkg::t_result o_res
);
    import nfr_pkg::*;

    logic [16:0] next_ticks;
    logic [3:0]  nib;
    logic [7:0]  full;

    assign next_ticks = {1'b0, i_state.elapsed_ticks} + 17'd1;
    assign nib        = i_rx_byte[7:4];
    assign full       = {i_state.high_nibble, nib};

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '{kind: K_DATA, data_byte: 8'd0, byte_index: 8'd0, frame_length: 8'd0};
        if (i_func) begin
            if (next_ticks >= {1'b0, i_cfg.timeout_ticks}) begin
                o_state     = StateIdle;
                o_res_valid = 1'b1;
                o_res.kind  = K_TIMEOUT;
            end else begin
                o_state.elapsed_ticks = next_ticks[15:0];
            end
        end else if (i_rx_byte == i_cfg.start_code) begin
            o_state          = StateIdle;
            o_state.in_frame = 1'b1;
        end else if (i_rx_byte == i_cfg.end_code) begin
            if (i_state.in_frame) begin
                o_state.seen_end = 1'b1;
            end
        end else if (!i_state.in_frame) begin
            o_state = i_state;
        end else if (nib != ~i_rx_byte[3:0]) begin
            o_state     = StateIdle;
            o_res_valid = 1'b1;
            o_res.kind  = K_BAD_CHAR;
        end else if (i_state.expect_high) begin
            o_state.high_nibble = nib;
            o_state.expect_high = 1'b0;
        end else if (i_state.seen_end) begin
            o_state     = StateIdle;
            o_res_valid = 1'b1;
            if (full == i_state.running_crc) begin
                o_res.kind         = K_OK;
                o_res.frame_length = i_state.payload_count;
            end else begin
                o_res.kind = K_BAD_CRC;
            end
        end else if (i_state.payload_count < i_cfg.max_payload) begin
            o_state.expect_high   = 1'b1;
            o_state.running_crc   = crc8_byte(i_state.running_crc, full);
            o_state.payload_count = i_state.payload_count + 8'd1;
            o_res_valid           = 1'b1;
            o_res.kind            = K_DATA;
            o_res.data_byte       = full;
            o_res.byte_index      = i_state.payload_count;
        end else begin
            o_state     = StateIdle;
            o_res_valid = 1'b1;
            o_res.kind  = K_OVERFLOW;
        end
    end

endmodule

// File: sim/tb_nibble_complement_frame_receiver_top.sv
// Self-checking testbench for the nibble-complement frame receiver.
`timescale 1ns / 100ps

module tb_nibble_complement_frame_receiver_top;
    import nfr_pkg::*;

    localparam int          TailCycles = 8;
    localparam int unsigned CycleLimit = 600000;
    localparam t_cfg RegsAtReset = '{
        timeout_ticks: 16'd100,
        max_payload:   8'd255,
        start_code:    8'd2,
        end_code:      8'd3
    };

    typedef struct packed {
        logic       func;
        logic [7:0] rx;
    } t_line_req;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [InDataW-1:0]   s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OutDataW-1:0]  m_axis_tdata;
    logic [KindW-1:0]     m_axis_tuser;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CfgIdxW-1:0]   i_cfg_index   = '0;
    logic [CfgDataW-1:0]  i_cfg_data    = '0;

    t_line_req   line_queue[$];
    t_result     awaited_reports[$];
    t_state      rx_st    = StateIdle;
    t_cfg        regs     = RegsAtReset;
    t_cfg        gen_cfg  = RegsAtReset;
    t_line_req   next_req;
    t_result     outcome;
    t_result     seen;
    t_result     want;
    int          send_gap;
    int          stall_left;
    int          send_odds;
    int          stall_odds;
    int          made_items;
    int          fault_count;
    int          bytes_taken;
    int          ticks_taken;
    int          kind_tally[6];
    int unsigned cycle_count;

    nibble_complement_frame_receiver_top dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic logic [7:0] crc8_advance(input logic [7:0] crc_in, input logic [7:0] v);
        logic [7:0] crc;
        logic       fb;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb  = crc[0] ^ v[i];
            crc = {1'b0, crc[7:1]} ^ (fb ? 8'h8C : 8'h00);
        end
        return crc;
    endfunction

    function automatic bit decode_line(input t_line_req r, output t_result res);
        logic [16:0] next_ticks;
        logic [7:0]  full;
        logic [7:0]  len;
        res = '0;
        if (r.func) begin
            next_ticks = {1'b0, rx_st.elapsed_ticks} + 17'd1;
            if (next_ticks >= {1'b0, regs.timeout_ticks}) begin
                rx_st    = StateIdle;
                res.kind = K_TIMEOUT;
                return 1'b1;
            end
            rx_st.elapsed_ticks = next_ticks[15:0];
            return 1'b0;
        end
        if (r.rx == regs.start_code) begin
            rx_st          = StateIdle;
            rx_st.in_frame = 1'b1;
            return 1'b0;
        end
        if (r.rx == regs.end_code) begin
            if (rx_st.in_frame) begin
                rx_st.seen_end = 1'b1;
            end
            return 1'b0;
        end
        if (!rx_st.in_frame) begin
            return 1'b0;
        end
        if (r.rx[7:4] != ~r.rx[3:0]) begin
            rx_st    = StateIdle;
            res.kind = K_BAD_CHAR;
            return 1'b1;
        end
        if (rx_st.expect_high) begin
            rx_st.high_nibble = r.rx[7:4];
            rx_st.expect_high = 1'b0;
            return 1'b0;
        end
        full              = {rx_st.high_nibble, r.rx[7:4]};
        rx_st.expect_high = 1'b1;
        if (rx_st.seen_end) begin
            len = rx_st.payload_count;
            if (full == rx_st.running_crc) begin
                res.kind         = K_OK;
                res.frame_length = len;
            end else begin
                res.kind = K_BAD_CRC;
            end
            rx_st = StateIdle;
            return 1'b1;
        end
        if (rx_st.payload_count < regs.max_payload) begin
            res.kind            = K_DATA;
            res.data_byte       = full;
            res.byte_index      = rx_st.payload_count;
            rx_st.running_crc   = crc8_advance(rx_st.running_crc, full);
            rx_st.payload_count = rx_st.payload_count + 8'd1;
            return 1'b1;
        end
        rx_st    = StateIdle;
        res.kind = K_OVERFLOW;
        return 1'b1;
    endfunction

    function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                      input logic [CfgDataW-1:0] val);
        case (idx)
            RegTimeout: regs.timeout_ticks = val;
            RegMaxPay:  regs.max_payload   = val[7:0];
            RegStart:   regs.start_code    = val[7:0];
            RegEnd:     regs.end_code      = val[7:0];
            default: ;
        endcase
    endfunction

    // Line request driver and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
            rx_st    = StateIdle;
            regs     = RegsAtReset;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser) begin
                    ticks_taken++;
                end else begin
                    bytes_taken++;
                end
                if (decode_line(t_line_req'({s_axis_tuser, s_axis_tdata}), outcome)) begin
                    awaited_reports.push_back(outcome);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg(i_cfg_index, i_cfg_data);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (line_queue.size() != 0) begin
                    next_req = line_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_req.func;
                    s_axis_tdata  <= next_req.rx;
                    if (send_odds != 0 && $urandom_range(1, 100) <= send_odds) begin
                        send_gap = $urandom_range(1, 17);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic flag_fault(input string what, input t_result exp_r, input t_result act_r);
        fault_count++;
        if (fault_count <= 10) begin
            $display("[%0t] %s: expected kind %0d data %02h index %0d length %0d,",
                     $time, what, exp_r.kind, exp_r.data_byte, exp_r.byte_index,
                     exp_r.frame_length);
            $display("    got kind %0d data %02h index %0d length %0d",
                     act_r.kind, act_r.data_byte, act_r.byte_index, act_r.frame_length);
        end
    endtask

    // Report monitor with random backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.kind         = t_kind'(m_axis_tuser);
                seen.data_byte    = m_axis_tdata[7:0];
                seen.byte_index   = m_axis_tdata[15:8];
                seen.frame_length = m_axis_tdata[23:16];
                if (m_axis_tuser <= K_TIMEOUT) begin
                    kind_tally[m_axis_tuser]++;
                end
                if (awaited_reports.size() == 0) begin
                    flag_fault("report with nothing outstanding", '0, seen);
                end else begin
                    want = awaited_reports.pop_front();
                    if (seen.kind !== want.kind || seen.data_byte !== want.data_byte ||
                        seen.byte_index !== want.byte_index ||
                        seen.frame_length !== want.frame_length) begin
                        flag_fault("report mismatch", want, seen);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
                stall_left = $urandom_range(1, 17) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic put_line(input logic [7:0] b);
        line_queue.push_back('{func: 1'b0, rx: b});
        made_items++;
    endtask

    task automatic put_tick();
        line_queue.push_back('{func: 1'b1, rx: 8'($urandom)});
        made_items++;
    endtask

    task automatic put_coded(input logic [7:0] v);
        put_line({v[7:4], ~v[7:4]});
        put_line({v[3:0], ~v[3:0]});
    endtask

    task automatic put_noise();
        repeat ($urandom_range(1, 4)) line_queue.push_back('{func: 1'b0, rx: 8'($urandom)});
    endtask

    task automatic put_frame(input int len, input bit good);
        logic [7:0] crc;
        logic [7:0] v;
        crc = 8'h00;
        put_line(gen_cfg.start_code);
        for (int i = 0; i < len; i++) begin
            v   = 8'($urandom);
            crc = crc8_advance(crc, v);
            put_coded(v);
            if ($urandom_range(0, 19) == 0) begin
                put_tick();
            end
        end
        put_line(gen_cfg.end_code);
        put_coded(good ? crc : crc ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic put_broken_frame();
        logic [7:0] b;
        logic [3:0] nib;
        put_line(gen_cfg.start_code);
        repeat ($urandom_range(0, 4)) put_coded(8'($urandom));
        case ($urandom_range(0, 2))
            0: begin
                do begin
                    b = 8'($urandom);
                end while (b[7:4] == ~b[3:0] || b == gen_cfg.start_code ||
                           b == gen_cfg.end_code);
                put_line(b);
            end
            1: put_frame($urandom_range(0, 4), 1'b1);
            default: begin
                nib = 4'($urandom);
                put_line({nib, ~nib});
                put_line(gen_cfg.end_code);
                put_coded(8'($urandom));
            end
        endcase
    endtask

    task automatic run_mix(input int budget);
        int pick;
        int cap;
        int len;
        made_items = 0;
        while (made_items < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                cap = (gen_cfg.max_payload < 39) ? gen_cfg.max_payload + 1 : 40;
                len = ($urandom_range(0, 6) == 0) ? $urandom_range(0, cap)
                                                  : $urandom_range(0, 6);
                put_frame(len, $urandom_range(0, 9) != 0);
            end else if (pick < 67) begin
                put_broken_frame();
            end else if (pick < 77) begin
                cap = (gen_cfg.timeout_ticks <= 140) ? gen_cfg.timeout_ticks + 2 : 20;
                repeat ($urandom_range(1, cap)) put_tick();
            end else if (pick < 87) begin
                put_noise();
            end else if (gen_cfg.max_payload < 40) begin
                put_frame(gen_cfg.max_payload + 1, 1'b1);
            end else begin
                put_frame($urandom_range(0, 6), 1'b1);
            end
        end
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
    endtask

    task automatic load_regs(input t_cfg c);
        write_reg(RegTimeout, c.timeout_ticks);
        write_reg(RegMaxPay, {8'd0, c.max_payload});
        write_reg(RegStart, {8'd0, c.start_code});
        write_reg(RegEnd, {8'd0, c.end_code});
        i_cfg_valid <= 1'b0;
        gen_cfg = c;
        @(posedge i_clk);
    endtask

    task automatic settle();
        while (line_queue.size() != 0 || s_axis_tvalid || awaited_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TailCycles) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_cfg c, input int s_odds, input int r_odds,
                             input int budget);
        load_regs(c);
        send_odds  = s_odds;
        stall_odds = r_odds;
        run_mix(budget);
        settle();
    endtask

    initial begin
        t_cfg       c;
        logic [7:0] crc;
        send_odds  = 10;
        stall_odds = 5;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        put_tick();
        put_line(8'h5A);
        put_line(RegsAtReset.end_code);
        put_line(RegsAtReset.start_code);
        put_coded(8'h0F);
        put_coded(8'hF0);
        put_line(8'hF0);
        put_line(RegsAtReset.end_code);
        put_line(8'hF0);
        put_coded(8'h00);
        put_line(RegsAtReset.end_code);
        put_line(RegsAtReset.end_code);
        crc = crc8_advance(crc8_advance(crc8_advance(crc8_advance(8'h00, 8'h0F), 8'hF0),
                                        8'hFF), 8'h00);
        put_coded(crc);
        put_line(RegsAtReset.start_code);
        put_coded(8'h0F);
        put_line(RegsAtReset.end_code);
        put_coded(crc8_advance(8'h00, 8'h0F) ^ 8'h01);
        put_line(RegsAtReset.start_code);
        put_line(8'h12);
        settle();

        c = '{timeout_ticks: 16'd30, max_payload: 8'd255, start_code: 8'd2, end_code: 8'd3};
        load_regs(c);
        send_odds  = 15;
        stall_odds = 3;
        put_frame(255, 1'b1);
        run_mix(180);
        settle();

        run_phase('{timeout_ticks: 16'd1, max_payload: 8'd0, start_code: 8'h00,
                    end_code: 8'hFF}, 30, 0, 180);
        run_phase('{timeout_ticks: 16'hFFFF, max_payload: 8'd1, start_code: 8'hA5,
                    end_code: 8'h5A}, 0, 8, 180);
        run_phase('{timeout_ticks: 16'd5, max_payload: 8'd3, start_code: 8'h7E,
                    end_code: 8'h7E}, 20, 4, 180);

        c.timeout_ticks = 16'($urandom_range(1, 40));
        c.max_payload   = 8'($urandom_range(0, 20));
        c.start_code    = 8'($urandom);
        c.end_code      = 8'($urandom);
        run_phase(c, 40, 8, 180);

        c.timeout_ticks = 16'($urandom_range(2, 60));
        c.max_payload   = 8'($urandom_range(1, 255));
        c.start_code    = 8'($urandom);
        c.end_code      = 8'($urandom);
        run_phase(c, 0, 0, 180);

        $display("covered %0d line bytes and %0d ticks under 7 register settings",
                 bytes_taken, ticks_taken);
        $display("reports: %0d data, %0d good, %0d bad char, %0d bad crc,",
                 kind_tally[K_DATA], kind_tally[K_OK], kind_tally[K_BAD_CHAR],
                 kind_tally[K_BAD_CRC]);
        $display("         %0d overflow, %0d timeout",
                 kind_tally[K_OVERFLOW], kind_tally[K_TIMEOUT]);
        if (fault_count == 0 && awaited_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CycleLimit);
        $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
src/nfr_pkg.sv
src/nfr_step.sv
src/nibble_complement_frame_receiver_top.sv
sim/tb_nibble_complement_frame_receiver_top.sv
